FILE: hw/rtl/remote_packet_rle_decoder_defines.svh
// Assertion macros used by the checker file.
`ifndef REMOTE_PACKET_RLE_DECODER_DEFINES_SVH
`define REMOTE_PACKET_RLE_DECODER_DEFINES_SVH

// Same-cycle property, sampled on the rising clock edge outside reset.
`define RPRD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Next-cycle implication.
`define RPRD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/rprd_pkg.sv
`default_nettype none

package rprd_pkg;

  localparam int LenWidth   = 16;
  localparam int LimitWidth = 16;
  localparam int CalcWidth  = (LenWidth > LimitWidth) ? LenWidth : LimitWidth;

  localparam logic [7:0] StarCode  = 8'h2A;
  localparam logic [7:0] XCode     = 8'h78;
  localparam logic [7:0] ZeroCode  = 8'h30;
  localparam logic [7:0] CountBias = 8'd29;
  localparam logic [7:0] CountEnd  = 8'd128;

  localparam logic [LimitWidth-1:0] LimitReset = LimitWidth'(4096);

  // One classified input byte, as handed from the front to the back.
  typedef struct packed {
    logic [7:0] raw;
    logic [7:0] lit;
    logic       is_star;
    logic       count_inf;
    logic [6:0] count;
    logic       eop;
  } cmd_t;

  typedef struct packed {
    logic [7:0]          out_byte;
    logic [LenWidth-1:0] run_length;
    logic                is_final;
    logic [LenWidth-1:0] total_length;
  } res_t;

endpackage

`default_nettype wire

FILE: hw/rtl/rprd_front.sv
`default_nettype none

module rprd_front import rprd_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  output logic            full_o,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       end_of_packet_i,
  output logic            cmd_valid_o,
  input  wire logic       cmd_ready_i,
  output cmd_t            cmd_o
);

  cmd_t       cls;
  cmd_t       mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       wr_en, rd_en;

  // Decode everything that does not depend on packet state.
  always_comb begin
    cls.raw       = in_byte_i;
    cls.lit       = (in_byte_i == XCode) ? ZeroCode : in_byte_i;
    cls.is_star   = (in_byte_i == StarCode);
    cls.count_inf = (in_byte_i < CountBias) || (in_byte_i >= CountEnd);
    cls.count     = 7'(in_byte_i - CountBias);
    cls.eop       = end_of_packet_i;
  end

  assign full_o      = cnt_q[1];
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = mem_q[rd_ptr_q];
  assign wr_en       = push_i && !full_o;
  assign rd_en       = cmd_valid_o && cmd_ready_i;

  always_comb begin
    wr_ptr_d = wr_en ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = rd_en ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!wr_en && rd_en) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/rprd_back.sv
`default_nettype none

module rprd_back import rprd_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [LimitWidth-1:0] cfg_data_i,
  input  wire logic                  cmd_valid_i,
  output logic                       cmd_ready_o,
  input  wire cmd_t                  cmd_i,
  output logic                       res_empty_o,
  input  wire logic                  res_pop_i,
  output res_t                       res_o
);

  logic [LimitWidth-1:0] limit_q;
  logic [7:0]            prev_q, prev_d;
  logic                  star_q, star_d;
  logic [LenWidth-1:0]   wc_q, wc_d;

  logic [CalcWidth-1:0]  wc_ext, lim_ext, room, cnt_ext, run_len;
  logic [7:0]            run_byte;
  logic                  have_run, step, emit;
  logic [LenWidth-1:0]   wc_new;
  res_t                  res_d;

  res_t                  mem_q [2];
  logic                  wr_ptr_q, rd_ptr_q;
  logic [1:0]            cnt_q, cnt_d;
  logic                  rd_en, res_full;

  assign cfg_ready_o = 1'b1;
  assign res_full    = cnt_q[1];
  assign cmd_ready_o = !res_full;
  assign step        = cmd_valid_i && !res_full;

  assign wc_ext  = CalcWidth'(wc_q);
  assign lim_ext = CalcWidth'(limit_q);
  assign room    = lim_ext - wc_ext;
  assign cnt_ext = CalcWidth'(cmd_i.count);

  always_comb begin
    prev_d   = prev_q;
    star_d   = star_q;
    run_byte = 8'd0;
    run_len  = '0;
    have_run = 1'b0;
    // Once the buffer is full every byte is ignored, stars included.
    if (wc_ext < lim_ext) begin
      if (star_q) begin
        if (cmd_i.count_inf || (cnt_ext > room)) begin
          run_len = room;
        end else begin
          run_len = cnt_ext;
        end
        run_byte = prev_q;
        have_run = (run_len != '0);
        star_d   = 1'b0;
        prev_d   = cmd_i.raw;
      end else if (cmd_i.is_star) begin
        star_d = 1'b1;
      end else begin
        run_byte = cmd_i.lit;
        run_len  = CalcWidth'(1);
        have_run = 1'b1;
        prev_d   = cmd_i.raw;
      end
    end
    wc_new = LenWidth'(wc_ext + run_len);
    wc_d   = wc_new;
    if (cmd_i.eop) begin
      prev_d = 8'd0;
      star_d = 1'b0;
      wc_d   = '0;
    end
    emit               = have_run || cmd_i.eop;
    res_d.out_byte     = have_run ? run_byte : 8'd0;
    res_d.run_length   = have_run ? LenWidth'(run_len) : '0;
    res_d.is_final     = cmd_i.eop;
    res_d.total_length = wc_new;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LimitReset;
      prev_q  <= 8'd0;
      star_q  <= 1'b0;
      wc_q    <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        limit_q <= cfg_data_i;
      end
      if (step) begin
        prev_q <= prev_d;
        star_q <= star_d;
        wc_q   <= wc_d;
      end
    end
  end

  // Two-entry result queue decouples the run engine from the consumer.
  assign res_empty_o = (cnt_q == 2'd0);
  assign res_o       = mem_q[rd_ptr_q];
  assign rd_en       = !res_empty_o && res_pop_i;

  always_comb begin
    cnt_d = cnt_q;
    if ((step && emit) && !rd_en) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!(step && emit) && rd_en) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && emit) begin
      mem_q[wr_ptr_q] <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (step && emit) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (rd_en) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/remote_packet_rle_decoder.sv
// Channel     Direction  Handshake            Payload
// input       in         push / full          in_byte_i, end_of_packet_i
// result      out        empty / pop          out_byte_o, run_length_o, is_final_o,
//                                             total_length_o
// config      in         cfg_valid_i / ready  cfg_data_i (out_limit)
//
// One byte is taken per cycle while full is low.
// The classify queue and the result queue hold two entries each, so a consumer that
// pops every cycle sees a sustained rate of up to one run per cycle.
// Reset clears the packet state and sets out_limit to 4096; no clearing pass is needed.
// A stalled consumer fills the result queue, then the classify queue, then raises full.
`default_nettype none

module remote_packet_rle_decoder import rprd_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push,
  output logic                       full,
  input  wire logic [7:0]            in_byte_i,
  input  wire logic                  end_of_packet_i,
  output logic                       empty,
  input  wire logic                  pop,
  output logic [7:0]                 out_byte_o,
  output logic [LenWidth-1:0]        run_length_o,
  output logic                       is_final_o,
  output logic [LenWidth-1:0]        total_length_o,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [LimitWidth-1:0] cfg_data_i
);

  cmd_t cmd;
  logic cmd_valid, cmd_ready;
  res_t res;

  rprd_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push_i          (push),
    .full_o          (full),
    .in_byte_i       (in_byte_i),
    .end_of_packet_i (end_of_packet_i),
    .cmd_valid_o     (cmd_valid),
    .cmd_ready_i     (cmd_ready),
    .cmd_o           (cmd)
  );

  rprd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .res_empty_o (empty),
    .res_pop_i   (pop),
    .res_o       (res)
  );

  assign out_byte_o     = res.out_byte;
  assign run_length_o   = res.run_length;
  assign is_final_o     = res.is_final;
  assign total_length_o = res.total_length;

endmodule

`default_nettype wire

FILE: hw/rtl/rprd_checker.sv
`default_nettype none
`include "remote_packet_rle_decoder_defines.svh"

module rprd_checker import rprd_pkg::*; (
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  push,
  input wire logic                  full,
  input wire logic [7:0]            in_byte_i,
  input wire logic                  end_of_packet_i,
  input wire logic                  empty,
  input wire logic                  pop,
  input wire logic [7:0]            out_byte_o,
  input wire logic [LenWidth-1:0]   run_length_o,
  input wire logic                  is_final_o,
  input wire logic [LenWidth-1:0]   total_length_o,
  input wire logic                  cfg_valid_i,
  input wire logic                  cfg_ready_o,
  input wire logic [LimitWidth-1:0] cfg_data_i
);

  // A waiting result must not change until it is popped.
  `RPRD_ASSERT_NEXT(a_res_hold, !empty && !pop, !empty && $stable(out_byte_o) && $stable(run_length_o) && $stable(is_final_o) && $stable(total_length_o), "result changed while stalled")

  // A run is counted into the running total.
  `RPRD_ASSERT(a_run_in_total, empty || (run_length_o <= total_length_o), "run exceeds total length")

  // Only the closing report may carry an empty run.
  `RPRD_ASSERT(a_nonfinal_run, empty || is_final_o || (run_length_o != '0), "empty run that is not final")

  // A bare final report carries a zero byte.
  `RPRD_ASSERT(a_bare_final, empty || (run_length_o != '0) || (out_byte_o == 8'd0), "bare report with nonzero byte")

endmodule

bind remote_packet_rle_decoder rprd_checker u_rprd_checker (.*);

`default_nettype wire
